// ===== rtl/rc_pwm_to_joystick_axes_defines.svh =====
// Assertion macros shared by the joystick axis block.
`ifndef RC_PWM_TO_JOYSTICK_AXES_DEFINES_SVH
`define RC_PWM_TO_JOYSTICK_AXES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPJ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpj assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpj assertion failed");

`endif

// ===== rtl/rpj_pkg.sv =====
// Types and constants of the RC pulse width to joystick axis block.
package rpj_pkg;

    localparam int PADDR_W = 5;
    localparam int NUM_W   = 26;   // |w - mid| * 16384 fits in 26 bits
    localparam int DEN_W   = 11;   // |delta| is at most 2047
    localparam int STEP_W  = 5;

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic        [14:0] Q14_ONE_MAG = 15'd16384;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PWM_MAX        = 3'd0;
    localparam logic [2:0] REG_PWM_MIN        = 3'd1;
    localparam logic [2:0] REG_DEADZONE       = 3'd2;
    localparam logic [2:0] REG_AXIS_MAP       = 3'd3;
    localparam logic [2:0] REG_AXIS_REVERSE   = 3'd4;
    localparam logic [2:0] REG_BUTTON_MAP     = 3'd5;
    localparam logic [2:0] REG_BUTTON_REVERSE = 3'd6;

    // Reset values of the registers.
    localparam logic [11:0] RST_PWM_MAX        = 12'd2000;
    localparam logic [11:0] RST_PWM_MIN        = 12'd1000;
    localparam logic [7:0]  RST_DEADZONE       = 8'd2;
    localparam logic [15:0] RST_AXIS_MAP       = 16'h3210;
    localparam logic [3:0]  RST_AXIS_REVERSE   = 4'h0;
    localparam logic [7:0]  RST_BUTTON_MAP     = 8'h54;
    localparam logic [1:0]  RST_BUTTON_REVERSE = 2'h0;

    typedef struct packed {
        logic [11:0] pwm_max;
        logic [11:0] pwm_min;
        logic [7:0]  deadzone;
        logic [15:0] axis_map;
        logic [3:0]  axis_reverse;
        logic [7:0]  button_map;
        logic [1:0]  button_reverse;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic             zero;
        logic [NUM_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] value;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_SCALE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/rpj_regs.sv =====
// APB register file holding the clamp, deadzone, map and reverse settings.
module rpj_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpj_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rpj_pkg::cfg_t                 cfg
);
    import rpj_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_PWM_MAX:        cfg_next.pwm_max        = pwdata[11:0];
                REG_PWM_MIN:        cfg_next.pwm_min        = pwdata[11:0];
                REG_DEADZONE:       cfg_next.deadzone       = pwdata[7:0];
                REG_AXIS_MAP:       cfg_next.axis_map       = pwdata[15:0];
                REG_AXIS_REVERSE:   cfg_next.axis_reverse   = pwdata[3:0];
                REG_BUTTON_MAP:     cfg_next.button_map     = pwdata[7:0];
                REG_BUTTON_REVERSE: cfg_next.button_reverse = pwdata[1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_PWM_MAX:        prdata = {20'd0, cfg_reg.pwm_max};
            REG_PWM_MIN:        prdata = {20'd0, cfg_reg.pwm_min};
            REG_DEADZONE:       prdata = {24'd0, cfg_reg.deadzone};
            REG_AXIS_MAP:       prdata = {16'd0, cfg_reg.axis_map};
            REG_AXIS_REVERSE:   prdata = {28'd0, cfg_reg.axis_reverse};
            REG_BUTTON_MAP:     prdata = {24'd0, cfg_reg.button_map};
            REG_BUTTON_REVERSE: prdata = {30'd0, cfg_reg.button_reverse};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_max        <= RST_PWM_MAX;
            cfg_reg.pwm_min        <= RST_PWM_MIN;
            cfg_reg.deadzone       <= RST_DEADZONE;
            cfg_reg.axis_map       <= RST_AXIS_MAP;
            cfg_reg.axis_reverse   <= RST_AXIS_REVERSE;
            cfg_reg.button_map     <= RST_BUTTON_MAP;
            cfg_reg.button_reverse <= RST_BUTTON_REVERSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/rpj_div.sv =====
// Shared restoring divider, one quotient bit a cycle, with Q1.14 saturation.
module rpj_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rpj_pkg::div_req_t req,
    output rpj_pkg::div_rsp_t rsp
);
    import rpj_pkg::*;

    logic [NUM_W-1:0]  qd_reg, qd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [14:0]       mag;

    assign trial = {rem_reg, qd_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            qd_next   = req.num_mag;
            rem_next  = '0;
            den_next  = req.den_mag;
            cnt_next  = STEP_W'(NUM_W - 1);
            busy_next = 1'b1;
            neg_next  = req.neg;
            zero_next = req.zero;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            qd_next  = {qd_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Quotient magnitude saturates at one, then takes the sign.
    assign mag = (qd_reg > NUM_W'(Q14_ONE_MAG)) ? Q14_ONE_MAG : qd_reg[14:0];

    always_comb
    begin
        rsp.done = done_reg;
        if (zero_reg)
            rsp.value = '0;
        else if (neg_reg)
            rsp.value = -$signed({1'b0, mag});
        else
            rsp.value = $signed({1'b0, mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg   <= qd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

endmodule

// ===== rtl/rc_pwm_to_joystick_axes.sv =====
// Top level: RC pulse widths to normalized joystick axis and button results.
//
//  Channel   Direction  Handshake                       Payload
//  input     in         in_valid / in_ready             channel, pulse_width, end_of_frame
//  output    out        out_valid / out_ready           is_button, slot, axis_value,
//                                                       button_value, last
//  config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A sample that ends no frame, or ends a frame with nothing changed, passes the
// transfer and then a compare with the held width.
// A frame end with a change then produces AXES + BUTTONS results, each passing
// through fetch, scale, 26 steps of the shared divider and emit; the divider
// steps take up most of the run.
// Reset clears the valid bits of the held widths at once; no clearing pass.
// A result waits in the output register while the sequencer goes on; the
// sequencer stalls only when the next result finds that register still full.
`include "rc_pwm_to_joystick_axes_defines.svh"

module rc_pwm_to_joystick_axes #(
    parameter int CHANNELS = 16,
    parameter int AXES     = 4,
    parameter int BUTTONS  = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input sample transfer
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3:0]                  channel,
    input  logic [15:0]                 pulse_width,
    input  logic                        end_of_frame,
    // result transfer
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        is_button,
    output logic [1:0]                  slot,
    output logic signed [15:0]          axis_value,
    output logic signed [1:0]           button_value,
    output logic                        last,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpj_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rpj_pkg::*;

    localparam int TOTAL = AXES + BUTTONS;
    localparam int IDX_W = $clog2(TOTAL);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TOTAL - 1);
    localparam logic [IDX_W-1:0] IDX_AXES = IDX_W'(AXES);
    localparam logic [4:0]       CH_LIM   = 5'(CHANNELS);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rpj_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer and sample registers.
    state_t            state_reg, state_next;
    logic [3:0]        ch_reg;
    logic [15:0]       pw_reg;
    logic              eof_reg;
    logic              flag_reg, flag_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Held pulse widths: a small memory with one registered read port and a
    // valid bit per entry, so that an entry never written reads as zero.
    logic [15:0]         mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;
    logic [15:0]         rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_ok_reg;
    logic [3:0]          rd_ch;
    logic                rd_en;
    logic                mem_we;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               is_button_reg;
    logic [1:0]         slot_reg;
    logic signed [15:0] axis_value_reg;
    logic signed [1:0]  button_value_reg;
    logic               last_reg;
    logic               out_load;

    // Current result: group, slot, mapped channel and reverse bit.
    logic       cur_btn;
    logic [1:0] cur_slot;
    logic [3:0] map_ch;
    logic       cur_rev;

    assign cur_btn  = idx_reg >= IDX_AXES;
    assign cur_slot = cur_btn ? 2'(idx_reg - IDX_AXES) : 2'(idx_reg);
    assign map_ch   = cur_btn ? cfg.button_map[{cur_slot[0], 2'b00} +: 4]
                              : cfg.axis_map[{cur_slot, 2'b00} +: 4];
    assign cur_rev  = cur_btn ? cfg.button_reverse[cur_slot[0]]
                              : cfg.axis_reverse[cur_slot];

    assign rd_ch = (state_reg == ST_IDLE) ? channel : map_ch;
    assign rd_en = ((state_reg == ST_IDLE) && in_valid) || (state_reg == ST_FETCH);

    // Change detection against the held width of the sampled channel.
    logic [15:0]        held;
    logic signed [16:0] chg_diff;
    logic [16:0]        chg_abs;
    logic               chg;
    logic               ch_in_range;

    assign held        = rd_valid_reg ? rd_data_reg : 16'd0;
    assign chg_diff    = $signed({1'b0, pw_reg}) - $signed({1'b0, held});
    assign chg_abs     = chg_diff[16] ? 17'(-chg_diff) : 17'(chg_diff);
    assign ch_in_range = {1'b0, ch_reg} < CH_LIM;
    assign chg         = ch_in_range && (chg_abs > {9'd0, cfg.deadzone});

    // Clamp, center snap and scale operands as 18-bit signed values; the magnitudes are unsigned.
    logic signed [17:0] w, hi, lo, dz, mid, span, dlt, wc, num;
    logic [17:0]        num_abs, dlt_abs;

    assign w    = rd_ok_reg ? ((rd_valid_reg) ? $signed({2'b00, rd_data_reg}) : 18'sd0)
                            : 18'sd0;
    assign hi   = $signed({6'd0, cfg.pwm_max});
    assign lo   = $signed({6'd0, cfg.pwm_min});
    assign dz   = $signed({10'd0, cfg.deadzone});
    assign mid  = (hi + lo) >>> 1;
    assign span = hi - lo;
    // Halving that truncates toward zero for an inverted clamp pair.
    assign dlt  = (span < 0) ? ((span + 18'sd1) >>> 1) : (span >>> 1);

    always_comb
    begin
        priority if (w > hi)
            wc = hi;
        else if (w < lo)
            wc = lo;
        else if ((w < mid + dz) && (w > mid - dz))
            wc = mid;
        else
            wc = w;
    end

    assign num     = wc - mid;
    assign num_abs = (num < 0) ? 18'(-num) : 18'(num);
    assign dlt_abs = (dlt < 0) ? 18'(-dlt) : 18'(dlt);

    // Final value of the current result.
    logic signed [15:0] res_val;
    logic signed [1:0]  res_btn;

    assign res_val = cur_rev ? -div_rsp.value : div_rsp.value;

    always_comb
    begin
        priority if (!cur_btn)
            res_btn = 2'sd0;
        else if (res_val == Q14_ONE)
            res_btn = 2'sd1;
        else if (res_val == -Q14_ONE)
            res_btn = -2'sd1;
        else
            res_btn = 2'sd0;
    end

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = (eof_reg && (flag_reg || chg)) ? ST_FETCH : ST_IDLE;
            ST_FETCH:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (div_rsp.done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_load)
                    state_next = (idx_reg == IDX_LAST) ? ST_IDLE : ST_FETCH;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        flag_next       = flag_reg;
        idx_next        = idx_reg;
        div_req.start   = 1'b0;
        div_req.neg     = (num < 0) ^ (dlt < 0);
        div_req.zero    = (dlt == 0);
        div_req.num_mag = {num_abs[11:0], 14'd0};
        div_req.den_mag = dlt_abs[DEN_W-1:0];
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_CHECK:
            begin
                mem_we = chg;
                if (eof_reg && (flag_reg || chg))
                begin
                    flag_next = 1'b0;
                    idx_next  = '0;
                end
                else
                begin
                    flag_next = flag_reg || chg;
                end
            end
            ST_SCALE:
                div_req.start = 1'b1;
            ST_EMIT:
                if (out_load && (idx_reg != IDX_LAST))
                    idx_next = idx_reg + 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b0;
            idx_reg       <= '0;
            vld_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
                vld_reg[ch_reg[CH_W-1:0]] <= 1'b1;
            if (rd_en)
            begin
                rd_ok_reg    <= {1'b0, rd_ch} < CH_LIM;
                rd_valid_reg <= vld_reg[rd_ch[CH_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[ch_reg[CH_W-1:0]] <= pw_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_ch[CH_W-1:0]];
        if (in_valid && in_ready)
        begin
            ch_reg  <= channel;
            pw_reg  <= pulse_width;
            eof_reg <= end_of_frame;
        end
        if (out_load)
        begin
            is_button_reg    <= cur_btn;
            slot_reg         <= cur_slot;
            axis_value_reg   <= res_val;
            button_value_reg <= res_btn;
            last_reg         <= (idx_reg == IDX_LAST);
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_button    = is_button_reg;
    assign slot         = slot_reg;
    assign axis_value   = axis_value_reg;
    assign button_value = button_value_reg;
    assign last         = last_reg;

    // Axis results never carry a button value.
    `RPJ_ASSERT_NOW(a_axis_no_button, out_valid && !is_button, button_value == 2'sd0)
    // Every result stays within plus and minus one in Q1.14.
    `RPJ_ASSERT_NOW(a_value_range, out_valid, (axis_value <= Q14_ONE) && (axis_value >= -Q14_ONE))
    // The run always closes on a button result.
    `RPJ_ASSERT_NOW(a_last_is_button, out_valid && last, is_button)
    // An accepted sample is always followed by the change check, where the input is not ready.
    `RPJ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== bench/rc_pwm_to_joystick_axes_tb.sv =====
// Self-checking testbench for the RC pulse width to joystick axis block.
`timescale 1ns / 100ps

module rc_pwm_to_joystick_axes_tb;
    import rpj_pkg::*;

    // Result groups of the default build.
    localparam int N_AXES    = 4;
    localparam int N_BUTTONS = 2;

    // The receiver parks this long once so that the block fills up and stalls its input.
    localparam int PARK_CYCLES  = 600;
    // A sample that causes no result keeps the block busy in the change check after its
    // transfer, so a register write waits this long after the last result.
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES   = 250;
    // Longest quiet stretch of a correct run is the park plus one result.
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] width;
        logic        eof;
    } rc_sample_t;

    typedef struct packed {
        logic               is_button;
        logic [1:0]         slot;
        logic signed [15:0] axis;
        logic signed [1:0]  button;
        logic               last;
    } joy_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [3:0]           channel      = '0;
    logic [15:0]          pulse_width  = '0;
    logic                 end_of_frame = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 is_button;
    logic [1:0]           slot;
    logic signed [15:0]   axis_value;
    logic signed [1:0]    button_value;
    logic                 last;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [PADDR_W-1:0]   paddr        = '0;
    logic [31:0]          pwdata       = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Samples waiting to be offered, and the results the predictor expects.
    rc_sample_t  pending_samples[$];
    joy_result_t awaited_results[$];
    rc_sample_t  offered;

    // Predictor state: its own copy of the settings and of the held widths.
    cfg_t        model_cfg;
    logic [15:0] held_width_m[16] = '{default: '0};
    logic        frame_dirty_m    = 1'b0;

    int unsigned queued_n    = 0;
    int unsigned accepted_n  = 0;
    int unsigned errors      = 0;
    int unsigned tx_gap      = 0;
    int unsigned rx_stall    = 0;
    int unsigned park_count  = 0;
    int unsigned park_seen   = 0;
    int unsigned quiet_cycles = 0;
    logic        tx_calm     = 1'b0;
    logic        rx_calm     = 1'b0;

    rc_pwm_to_joystick_axes i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .channel      (channel),
        .pulse_width  (pulse_width),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_button    (is_button),
        .slot         (slot),
        .axis_value   (axis_value),
        .button_value (button_value),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Normalizes the held width of one channel: clamp against the maximum first and
    // then the minimum, snap to the midpoint inside the center zone, scale to Q1.14
    // with truncation toward zero, and saturate. A zero half-span gives zero.
    function automatic logic signed [15:0] normalized_width(logic [3:0] ch);
        longint w, hi, lo, dz, mid, span, q;
        w = held_width_m[ch];
        hi = model_cfg.pwm_max;
        lo = model_cfg.pwm_min;
        dz = model_cfg.deadzone;
        mid = (hi + lo) / 2;
        span = (hi - lo) / 2;
        if (w > hi)
            w = hi;
        else if (w < lo)
            w = lo;
        else if (w < mid + dz && w > mid - dz)
            w = mid;
        if (span == 0)
            return '0;
        q = (w - mid) * Q14_ONE / span;
        if (q > Q14_ONE)
            q = Q14_ONE;
        if (q < -Q14_ONE)
            q = -Q14_ONE;
        return 16'(q);
    endfunction

    // Applies one accepted sample to the predictor. A width that moves by more than
    // the deadzone is taken over and marks the frame dirty; a dirty frame end
    // expects every axis and then every button, the last button closing the run.
    function automatic void apply_sample(rc_sample_t s);
        int                 diff;
        logic signed [15:0] v;
        joy_result_t        r;
        diff = int'(s.width) - int'(held_width_m[s.channel]);
        if (diff < 0)
            diff = -diff;
        if (diff > int'(model_cfg.deadzone))
        begin
            held_width_m[s.channel] = s.width;
            frame_dirty_m = 1'b1;
        end
        if (!s.eof || !frame_dirty_m)
            return;
        frame_dirty_m = 1'b0;
        for (int i = 0; i < N_AXES; i++)
        begin
            v = normalized_width(model_cfg.axis_map[4*i +: 4]);
            if (model_cfg.axis_reverse[i])
                v = -v;
            r = '{is_button: 1'b0, slot: 2'(i), axis: v, button: 2'sd0, last: 1'b0};
            awaited_results = {awaited_results, r};
        end
        for (int i = 0; i < N_BUTTONS; i++)
        begin
            v = normalized_width(model_cfg.button_map[4*i +: 4]);
            if (model_cfg.button_reverse[i])
                v = -v;
            r = '{is_button: 1'b1, slot: 2'(i), axis: v, button: 2'(v / Q14_ONE),
                  last: (i == N_BUTTONS - 1)};
            awaited_results = {awaited_results, r};
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Sender: offers pending samples and, after each transfer, stays quiet for the
    // number of cycles drawn when that sample went out. Every accepted sample goes
    // through the predictor at the edge of its transfer.
    always @(posedge clk)
    begin : tx_side
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_sample(offered);
                accepted_n++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    offered = pending_samples.pop_front();
                    channel <= offered.channel;
                    pulse_width <= offered.width;
                    end_of_frame <= offered.eof;
                    in_valid <= 1'b1;
                    tx_gap <= tx_calm ? 0 : $urandom_range(0, 17);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result transfer against the oldest expectation, then
    // drops ready for a drawn number of cycles. A park request from the stimulus
    // holds ready low for a long stretch counted here.
    always @(posedge clk)
    begin : rx_side
        int unsigned nxt;
        joy_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            nxt = rx_stall;
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display({"%0t ns: result with nothing expected, expected none, ",
                              "got slot %0d value %0d"}, $time, slot, axis_value);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("is_button", want.is_button, is_button);
                    check_field("slot", want.slot, slot);
                    check_field("axis_value", want.axis, axis_value);
                    check_field("button_value", want.button, button_value);
                    check_field("last", want.last, last);
                end
                nxt = rx_calm ? 0 : $urandom_range(0, 17);
            end
            else if (nxt != 0)
            begin
                nxt = nxt - 1;
            end
            if (park_seen != park_count)
            begin
                nxt = PARK_CYCLES;
                park_seen <= park_count;
            end
            rx_stall <= nxt;
            out_ready <= (nxt == 0);
        end
    end

    // Ends the run when nothing has moved on any port for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one register through a setup and an access cycle, updates the
    // predictor's copy, and reads the register back.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd_want;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_PWM_MAX:        model_cfg.pwm_max = val[11:0];
            REG_PWM_MIN:        model_cfg.pwm_min = val[11:0];
            REG_DEADZONE:       model_cfg.deadzone = val[7:0];
            REG_AXIS_MAP:       model_cfg.axis_map = val[15:0];
            REG_AXIS_REVERSE:   model_cfg.axis_reverse = val[3:0];
            REG_BUTTON_MAP:     model_cfg.button_map = val[7:0];
            REG_BUTTON_REVERSE: model_cfg.button_reverse = val[1:0];
            default: ;
        endcase
        case (idx)
            REG_PWM_MAX:        rd_want = 32'(model_cfg.pwm_max);
            REG_PWM_MIN:        rd_want = 32'(model_cfg.pwm_min);
            REG_DEADZONE:       rd_want = 32'(model_cfg.deadzone);
            REG_AXIS_MAP:       rd_want = 32'(model_cfg.axis_map);
            REG_AXIS_REVERSE:   rd_want = 32'(model_cfg.axis_reverse);
            REG_BUTTON_MAP:     rd_want = 32'(model_cfg.button_map);
            default:            rd_want = 32'(model_cfg.button_reverse);
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== rd_want)
        begin
            $display("%0t ns: read back of register %0d mismatch, expected %0h, got %0h",
                     $time, idx, rd_want, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Blocks until every queued sample has been transferred and every expected
    // result has come back, then lets the block finish a sample without results.
    task automatic drain_and_pause(input int unsigned extra);
        while (accepted_n != queued_n || awaited_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [3:0] ch, input logic [15:0] w, input logic eof);
        rc_sample_t s;
        s = '{channel: ch, width: w, eof: eof};
        pending_samples = {pending_samples, s};
        queued_n++;
    endtask

    // Mostly plausible widths, with the extremes, raw 16-bit noise and widths
    // straddling the center zone of the current settings mixed in.
    function automatic logic [15:0] draw_width();
        int m, d;
        m = (int'(model_cfg.pwm_max) + int'(model_cfg.pwm_min)) / 2;
        d = int'(model_cfg.deadzone);
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            4:       return 16'(m - d - 1 + int'($urandom_range(0, 2 * d + 2)));
            default: return 16'(800 + $urandom_range(0, 1400));
        endcase
    endfunction

    // A frame walks channels upward from zero; an unclosed one never marks its end.
    task automatic queue_frame(input int unsigned n, input logic closed);
        for (int unsigned i = 0; i < n; i++)
            queue_sample(4'(i), draw_width(), closed && (i == n - 1));
    endtask

    function automatic logic [11:0] pick_clamp(int center);
        case ($urandom_range(0, 9))
            0:       return 12'h000;
            1:       return 12'hFFF;
            2:       return 12'($urandom);
            default: return 12'(center - 200 + int'($urandom_range(0, 400)));
        endcase
    endfunction

    // New settings for a random phase; every register is rewritten.
    task automatic retune();
        logic [31:0] dz;
        case ($urandom_range(0, 5))
            0:       dz = 32'd0;
            1:       dz = 32'hFF;
            2:       dz = $urandom;
            default: dz = $urandom_range(1, 16);
        endcase
        reg_write(REG_PWM_MAX, 32'(pick_clamp(2000)));
        reg_write(REG_PWM_MIN, 32'(pick_clamp(1000)));
        reg_write(REG_DEADZONE, dz);
        reg_write(REG_AXIS_MAP, ($urandom_range(0, 2) == 0) ? 32'h3210 : $urandom);
        reg_write(REG_AXIS_REVERSE, $urandom);
        reg_write(REG_BUTTON_MAP, ($urandom_range(0, 2) == 0) ? 32'h54 : $urandom);
        reg_write(REG_BUTTON_REVERSE, $urandom);
    endtask

    initial
    begin : stimulus
        int unsigned stop_at;
        model_cfg = '{pwm_max: RST_PWM_MAX, pwm_min: RST_PWM_MIN, deadzone: RST_DEADZONE,
                      axis_map: RST_AXIS_MAP, axis_reverse: RST_AXIS_REVERSE,
                      button_map: RST_BUTTON_MAP, button_reverse: RST_BUTTON_REVERSE};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings. The first frame drives one axis past each clamp, one to
        // the exact midpoint, one inside the center zone, and both buttons to the
        // ends of the range.
        queue_sample(4'd0, 16'hFFFF, 1'b0);
        queue_sample(4'd1, 16'h0000, 1'b0);
        queue_sample(4'd2, 16'd1500, 1'b0);
        queue_sample(4'd3, 16'd1501, 1'b0);
        queue_sample(4'd4, 16'd2000, 1'b0);
        queue_sample(4'd5, 16'd1000, 1'b1);
        // A frame end with nothing changed, then a move of exactly the deadzone,
        // neither of which may emit anything.
        queue_sample(4'd0, 16'hFFFF, 1'b1);
        queue_sample(4'd2, 16'd1502, 1'b1);
        // One step past the deadzone emits again.
        queue_sample(4'd2, 16'd1503, 1'b1);
        // A change on a channel that no output reads still emits a full run.
        queue_sample(4'd15, 16'h5A5A, 1'b1);
        queue_sample(4'd3, 16'd1497, 1'b1);
        queue_sample(4'd7, 16'hAAAA, 1'b0);
        queue_sample(4'd8, 16'h5555, 1'b1);
        queue_sample(4'd6, 16'h8000, 1'b1);
        drain_and_pause(SETTLE_CYCLES);

        // Widest clamps, widest deadzone, maps reaching the top channels and every
        // output reversed.
        reg_write(REG_PWM_MAX, 32'hFFF);
        reg_write(REG_PWM_MIN, 32'h0);
        reg_write(REG_DEADZONE, 32'hFF);
        reg_write(REG_AXIS_MAP, 32'hF0A5);
        reg_write(REG_AXIS_REVERSE, 32'hF);
        reg_write(REG_BUTTON_MAP, 32'h7F);
        reg_write(REG_BUTTON_REVERSE, 32'h3);
        queue_sample(4'd15, 16'h0000, 1'b0);
        queue_sample(4'd10, 16'hFFFF, 1'b0);
        queue_sample(4'd5, 16'd2047, 1'b0);
        queue_sample(4'd0, 16'h0000, 1'b1);
        drain_and_pause(SETTLE_CYCLES);

        // Clamps one apart: the half-span is zero, so every value is zero.
        reg_write(REG_PWM_MAX, 32'd1501);
        reg_write(REG_PWM_MIN, 32'd1500);
        reg_write(REG_DEADZONE, 32'd0);
        queue_sample(4'd1, 16'd3000, 1'b1);
        drain_and_pause(SETTLE_CYCLES);

        // Inverted clamps, first at the extremes where the result saturates, then
        // in the usual range.
        reg_write(REG_PWM_MAX, 32'd0);
        reg_write(REG_PWM_MIN, 32'hFFF);
        queue_sample(4'd2, 16'h0000, 1'b0);
        queue_sample(4'd3, 16'd4095, 1'b1);
        drain_and_pause(SETTLE_CYCLES);
        reg_write(REG_PWM_MAX, 32'd1000);
        reg_write(REG_PWM_MIN, 32'd2000);
        queue_sample(4'd4, 16'd1234, 1'b1);
        drain_and_pause(SETTLE_CYCLES);

        // Random phases: mostly whole frames with random widths, some unclosed
        // frames and stray samples. The third phase parks the receiver while four
        // dirty frames are offered, so the block has to stall its input.
        for (int phase = 0; phase < 6; phase++)
        begin
            retune();
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                park_count <= park_count + 1;
                repeat (4) queue_frame(6, 1'b1);
            end
            stop_at = queued_n + 8;
            while (queued_n < stop_at)
            begin
                case ($urandom_range(0, 9))
                    0:       queue_sample(4'($urandom), 16'($urandom),
                                          ($urandom_range(0, 3) == 0));
                    1:       queue_frame($urandom_range(1, 16), 1'b0);
                    default: queue_frame($urandom_range(1, 16), 1'b1);
                endcase
            end
            drain_and_pause(SETTLE_CYCLES);
        end

        drain_and_pause(END_CYCLES);
        if (errors == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== rc_pwm_to_joystick_axes.f =====
+incdir+rtl
rtl/rpj_pkg.sv
rtl/rpj_regs.sv
rtl/rpj_div.sv
rtl/rc_pwm_to_joystick_axes.sv
bench/rc_pwm_to_joystick_axes_tb.sv
